// ----- rtl/cpu_flag_alu_core_defines.svh -----
// Assertion macros used by the checker of the flag unit.
`ifndef CPU_FLAG_ALU_CORE_DEFINES_SVH
`define CPU_FLAG_ALU_CORE_DEFINES_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define CFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpu_flag_alu_core check failed");

// The expression must never be true outside reset.
`define CFA_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("cpu_flag_alu_core check failed");

`endif

// ----- rtl/cfa_pkg.sv -----
`default_nettype none
package cfa_pkg;

  typedef enum logic [3:0] {
    ACT_INC8  = 4'd0,
    ACT_DEC8  = 4'd1,
    ACT_RLCA  = 4'd2,
    ACT_RRCA  = 4'd3,
    ACT_RLA   = 4'd4,
    ACT_RRA   = 4'd5,
    ACT_SCF   = 4'd6,
    ACT_CCF   = 4'd7,
    ACT_CPL   = 4'd8,
    ACT_ADD16 = 4'd9
  } action_t;

  localparam int FL_S = 7;
  localparam int FL_Z = 6;
  localparam int FL_Y = 5;
  localparam int FL_H = 4;
  localparam int FL_X = 3;
  localparam int FL_P = 2;
  localparam int FL_N = 1;
  localparam int FL_C = 0;

  localparam logic [7:0] MASK_SZP = 8'hC4;
  localparam logic [7:0] MASK_YX  = 8'h28;
  localparam logic [7:0] MASK_C   = 8'h01;

  typedef struct packed {
    action_t     action;
    logic [7:0]  operand;
    logic [7:0]  flags;
    logic [15:0] hl;
    logic [15:0] pair;
  } op_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  flags;
  } res_t;

  // Sign, zero, undocumented copies and even parity of an 8-bit result.
  function automatic logic [7:0] szyxp(input logic [7:0] r);
    logic [7:0] f;
    f = 8'h00;
    f[FL_S] = r[7];
    f[FL_Z] = (r == 8'h00);
    f[FL_Y] = r[5];
    f[FL_X] = r[3];
    f[FL_P] = ~^r;
    return f;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cfa_exec.sv -----
`default_nettype none
module cfa_exec (
  input  cfa_pkg::op_t  op,
  output cfa_pkg::res_t res
);

  logic [7:0]  r8;
  logic [16:0] sum17;
  logic [12:0] half13;

  assign sum17  = {1'b0, op.hl} + {1'b0, op.pair};
  assign half13 = {1'b0, op.hl[11:0]} + {1'b0, op.pair[11:0]};

  always_comb begin
    r8 = op.operand;
    res.value = {8'h00, op.operand};
    res.flags = op.flags;
    case (op.action)
      cfa_pkg::ACT_INC8: begin
        r8 = op.operand + 8'd1;
        res.value = {8'h00, r8};
        res.flags = cfa_pkg::szyxp(r8) | (op.flags & cfa_pkg::MASK_C);
        res.flags[cfa_pkg::FL_H] = (op.operand[3:0] == 4'hF);
      end
      cfa_pkg::ACT_DEC8: begin
        r8 = op.operand - 8'd1;
        res.value = {8'h00, r8};
        res.flags = cfa_pkg::szyxp(r8) | (op.flags & cfa_pkg::MASK_C);
        res.flags[cfa_pkg::FL_N] = 1'b1;
        res.flags[cfa_pkg::FL_H] = (op.operand[3:0] == 4'h0);
      end
      cfa_pkg::ACT_RLCA, cfa_pkg::ACT_RLA: begin
        r8 = {op.operand[6:0], (op.action == cfa_pkg::ACT_RLA) ?
              op.flags[cfa_pkg::FL_C] : op.operand[7]};
        res.value = {8'h00, r8};
        res.flags = (op.flags & cfa_pkg::MASK_SZP) | (r8 & cfa_pkg::MASK_YX);
        res.flags[cfa_pkg::FL_C] = op.operand[7];
      end
      cfa_pkg::ACT_RRCA, cfa_pkg::ACT_RRA: begin
        r8 = {(op.action == cfa_pkg::ACT_RRA) ? op.flags[cfa_pkg::FL_C] : op.operand[0],
              op.operand[7:1]};
        res.value = {8'h00, r8};
        res.flags = (op.flags & cfa_pkg::MASK_SZP) | (r8 & cfa_pkg::MASK_YX);
        res.flags[cfa_pkg::FL_C] = op.operand[0];
      end
      cfa_pkg::ACT_SCF: begin
        res.flags = (op.flags & cfa_pkg::MASK_SZP) | (op.operand & cfa_pkg::MASK_YX)
                    | cfa_pkg::MASK_C;
      end
      cfa_pkg::ACT_CCF: begin
        res.flags = (op.flags & cfa_pkg::MASK_SZP) | (op.operand & cfa_pkg::MASK_YX);
        res.flags[cfa_pkg::FL_H] = op.flags[cfa_pkg::FL_C];
        res.flags[cfa_pkg::FL_C] = ~op.flags[cfa_pkg::FL_C];
      end
      cfa_pkg::ACT_CPL: begin
        r8 = ~op.operand;
        res.value = {8'h00, r8};
        res.flags = (op.flags & (cfa_pkg::MASK_SZP | cfa_pkg::MASK_C))
                    | (r8 & cfa_pkg::MASK_YX);
        res.flags[cfa_pkg::FL_H] = 1'b1;
        res.flags[cfa_pkg::FL_N] = 1'b1;
      end
      cfa_pkg::ACT_ADD16: begin
        res.value = sum17[15:0];
        res.flags = op.flags & cfa_pkg::MASK_SZP;
        res.flags[cfa_pkg::FL_H] = half13[12];
        res.flags[cfa_pkg::FL_C] = sum17[16];
      end
      default: begin
        res.value = {8'h00, op.operand};
        res.flags = op.flags;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/cpu_flag_alu_core.sv -----
// Result and flag unit for an 8-bit CPU execute stage.
// A transaction is offered on start together with action, operand_value,
// flags_in, hl_value and pair_value, and is taken at a rising edge where
// start is high and busy is low. Busy is never raised, so one transaction
// can be taken on every clock.
// The operands are captured in an input register, the flag logic sits
// between that register and the result register, and the result appears on
// result_value and flags_out with done high for exactly one cycle.
// Throughput is one transaction per cycle, set by the single
// register-to-register pass through the flag logic.
// The receiver cannot stall: each result is shown once and must be taken in
// that cycle.
// A synchronous reset clears the valid bits of both registers, so no result
// is presented for transactions in flight at reset.
`default_nettype none
module cpu_flag_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  action,
  input  logic [7:0]  operand_value,
  input  logic [7:0]  flags_in,
  input  logic [15:0] hl_value,
  input  logic [15:0] pair_value,
  output logic        done,
  output logic [15:0] result_value,
  output logic [7:0]  flags_out
);

  logic          op_valid;
  cfa_pkg::op_t  op;
  cfa_pkg::op_t  op_next;
  cfa_pkg::res_t res_next;

  assign busy = 1'b0;

  always_comb begin
    op_next.action  = cfa_pkg::action_t'(action);
    op_next.operand = operand_value;
    op_next.flags   = flags_in;
    op_next.hl      = hl_value;
    op_next.pair    = pair_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      op_valid <= start && !busy;
      done     <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= op_next;
    end
    if (op_valid) begin
      result_value <= res_next.value;
      flags_out    <= res_next.flags;
    end
  end

  cfa_exec u_exec (
    .op  (op),
    .res (res_next)
  );

endmodule
`default_nettype wire

// ----- rtl/cfa_checker.sv -----
`default_nettype none
`include "cpu_flag_alu_core_defines.svh"
module cfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [3:0]  action,
  input logic [7:0]  operand_value,
  input logic [7:0]  flags_in,
  input logic [15:0] hl_value,
  input logic [15:0] pair_value,
  input logic        done,
  input logic [15:0] result_value,
  input logic [7:0]  flags_out
);

  logic [3:0] unused_action;
  assign unused_action = action ^ operand_value[3:0] ^ flags_in[3:0]
                         ^ hl_value[3:0] ^ pair_value[3:0] ^ flags_out[3:0];

  `CFA_ASSERT_NEVER(a_never_busy, busy)
  `CFA_ASSERT_IMPL(a_result_follows, start && !busy, ##2 done)
  `CFA_ASSERT_IMPL(a_no_spurious_result, done, $past(start && !busy && !rst, 2))
  `CFA_ASSERT_IMPL(a_high_byte_clear,
    done && ($past(action, 2) != cfa_pkg::ACT_ADD16) && (unused_action == unused_action),
    result_value[15:8] == 8'h00)

endmodule

bind cpu_flag_alu_core cfa_checker u_checker (.*);
`default_nettype wire

// ----- tb/cpu_flag_alu_core_tb.sv -----
`default_nettype none
module cpu_flag_alu_core_tb;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  operand;
    logic [7:0]  flags;
    logic [15:0] hl;
    logic [15:0] pair;
  } alu_op_t;

  localparam logic [3:0] ACT_FIRST_UNUSED = 4'(cfa_pkg::ACT_ADD16) + 4'd1;
  localparam logic [3:0] ACT_LAST_CODE    = 4'hF;
  localparam int RANDOM_OPS = 650;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  action = 4'h0;
  logic [7:0]  operand_value = 8'h00;
  logic [7:0]  flags_in = 8'h00;
  logic [15:0] hl_value = 16'h0000;
  logic [15:0] pair_value = 16'h0000;
  logic        done;
  logic [15:0] result_value;
  logic [7:0]  flags_out;

  alu_op_t        pending_ops[$];
  cfa_pkg::res_t  predicted_flag_results[$];
  alu_op_t        staged_op;
  cfa_pkg::res_t  golden;
  int             idle_left = 0;
  int             burst_left = 0;
  int             mismatch_count = 0;

  cpu_flag_alu_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .operand_value(operand_value),
    .flags_in(flags_in),
    .hl_value(hl_value),
    .pair_value(pair_value),
    .done(done),
    .result_value(result_value),
    .flags_out(flags_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] sign_zero_parity(input logic [7:0] r);
    logic [7:0] f;
    f = r & cfa_pkg::MASK_YX;
    f[cfa_pkg::FL_S] = r[7];
    f[cfa_pkg::FL_Z] = ~|r;
    f[cfa_pkg::FL_P] = ~(^r);
    return f;
  endfunction

  function automatic cfa_pkg::res_t predict_flag_result(input alu_op_t op);
    cfa_pkg::res_t r;
    logic [7:0]    v;
    logic [7:0]    f;
    logic [7:0]    nv;
    logic [16:0]   sum;
    logic [12:0]   low_sum;
    logic          c;
    logic          out_bit;
    v = op.operand;
    f = op.flags;
    c = f[cfa_pkg::FL_C];
    nv = v;
    r.flags = f;
    case (op.action)
      cfa_pkg::ACT_INC8: begin
        nv = v + 8'd1;
        r.flags = sign_zero_parity(nv);
        r.flags[cfa_pkg::FL_H] = (v[3:0] == 4'hF);
        r.flags[cfa_pkg::FL_C] = c;
      end
      cfa_pkg::ACT_DEC8: begin
        nv = v - 8'd1;
        r.flags = sign_zero_parity(nv);
        r.flags[cfa_pkg::FL_H] = (v[3:0] == 4'h0);
        r.flags[cfa_pkg::FL_N] = 1'b1;
        r.flags[cfa_pkg::FL_C] = c;
      end
      cfa_pkg::ACT_RLCA, cfa_pkg::ACT_RLA: begin
        out_bit = v[7];
        nv = {v[6:0], (op.action == cfa_pkg::ACT_RLA) ? c : out_bit};
        r.flags = (f & cfa_pkg::MASK_SZP) | (nv & cfa_pkg::MASK_YX);
        r.flags[cfa_pkg::FL_C] = out_bit;
      end
      cfa_pkg::ACT_RRCA, cfa_pkg::ACT_RRA: begin
        out_bit = v[0];
        nv = {(op.action == cfa_pkg::ACT_RRA) ? c : out_bit, v[7:1]};
        r.flags = (f & cfa_pkg::MASK_SZP) | (nv & cfa_pkg::MASK_YX);
        r.flags[cfa_pkg::FL_C] = out_bit;
      end
      cfa_pkg::ACT_SCF: begin
        r.flags = (f & cfa_pkg::MASK_SZP) | (v & cfa_pkg::MASK_YX);
        r.flags[cfa_pkg::FL_C] = 1'b1;
      end
      cfa_pkg::ACT_CCF: begin
        r.flags = (f & cfa_pkg::MASK_SZP) | (v & cfa_pkg::MASK_YX);
        r.flags[cfa_pkg::FL_H] = c;
        r.flags[cfa_pkg::FL_C] = ~c;
      end
      cfa_pkg::ACT_CPL: begin
        nv = ~v;
        r.flags = (f & (cfa_pkg::MASK_SZP | cfa_pkg::MASK_C)) | (nv & cfa_pkg::MASK_YX);
        r.flags[cfa_pkg::FL_H] = 1'b1;
        r.flags[cfa_pkg::FL_N] = 1'b1;
      end
      default: ;
    endcase
    r.value = {8'h00, nv};
    if (op.action == cfa_pkg::ACT_ADD16) begin
      sum = {1'b0, op.hl} + {1'b0, op.pair};
      low_sum = {1'b0, op.hl[11:0]} + {1'b0, op.pair[11:0]};
      r.flags = f & cfa_pkg::MASK_SZP;
      r.flags[cfa_pkg::FL_H] = low_sum[12];
      r.flags[cfa_pkg::FL_C] = sum[16];
      r.value = sum[15:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < 40) begin
      $display("%0t %s: got %h, expected %h", $time, field, got, want);
    end
    mismatch_count++;
  endtask

  task automatic add_op(input logic [3:0] act, input logic [7:0] opnd, input logic [7:0] fl,
                        input logic [15:0] hl, input logic [15:0] pair);
    pending_ops.push_back('{act, opnd, fl, hl, pair});
  endtask

  function automatic int pick_idle();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] random_byte();
    if ($urandom_range(0, 9) < 7) return 8'($urandom);
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0F;
      3: return 8'h10;
      4: return 8'h7F;
      default: return 8'h80;
    endcase
  endfunction

  function automatic logic [15:0] random_word();
    if ($urandom_range(0, 9) < 7) return 16'($urandom);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0FFF;
      3: return 16'h1000;
      4: return 16'h8000;
      default: return {4'hF, 12'($urandom)};
    endcase
  endfunction

  function automatic logic [3:0] random_action();
    if ($urandom_range(0, 99) < 6) begin
      return 4'($urandom_range(int'(ACT_FIRST_UNUSED), int'(ACT_LAST_CODE)));
    end
    return 4'($urandom_range(0, int'(cfa_pkg::ACT_ADD16)));
  endfunction

  // A transaction is taken at an edge where start is high and busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_flag_results.push_back(predict_flag_result(
          '{action, operand_value, flags_in, hl_value, pair_value}));
      end
      if (!start || !busy) begin
        if (idle_left > 0 || pending_ops.size() == 0) begin
          if (idle_left > 0) idle_left--;
          start <= 1'b0;
          action <= 4'($urandom);
          operand_value <= 8'($urandom);
          flags_in <= 8'($urandom);
          hl_value <= 16'($urandom);
          pair_value <= 16'($urandom);
        end else begin
          staged_op = pending_ops.pop_front();
          action <= staged_op.action;
          operand_value <= staged_op.operand;
          flags_in <= staged_op.flags;
          hl_value <= staged_op.hl;
          pair_value <= staged_op.pair;
          start <= 1'b1;
          idle_left = pick_idle();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (predicted_flag_results.size() == 0) begin
        report_mismatch("unexpected result_value", result_value, 16'h0000);
      end else begin
        golden = predicted_flag_results.pop_front();
        if (result_value !== golden.value) begin
          report_mismatch("result_value", result_value, golden.value);
        end
        if (flags_out !== golden.flags) begin
          report_mismatch("flags_out", {8'h00, flags_out}, {8'h00, golden.flags});
        end
      end
    end
  end

  initial begin
    int i;
    int drain;
    add_op(cfa_pkg::ACT_INC8, 8'hFF, 8'h00, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_INC8, 8'h7F, 8'hFF, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_INC8, 8'h0F, 8'h01, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_DEC8, 8'h00, 8'h01, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_DEC8, 8'h01, 8'hFE, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_DEC8, 8'h80, 8'h00, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_RLCA, 8'h80, 8'h00, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_RRCA, 8'h01, 8'hFF, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_RLA, 8'h80, 8'h01, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_RLA, 8'h7F, 8'h00, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_RRA, 8'h01, 8'h00, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_RRA, 8'hFE, 8'hFF, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_SCF, 8'hFF, 8'h00, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_SCF, 8'h00, 8'hFF, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_CCF, 8'h28, 8'h01, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_CCF, 8'hD7, 8'hFE, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_CPL, 8'h00, 8'h00, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_CPL, 8'hFF, 8'hFF, 16'($urandom), 16'($urandom));
    add_op(cfa_pkg::ACT_ADD16, 8'($urandom), 8'hFF, 16'hFFFF, 16'hFFFF);
    add_op(cfa_pkg::ACT_ADD16, 8'($urandom), 8'h00, 16'h0FFF, 16'h0001);
    add_op(cfa_pkg::ACT_ADD16, 8'($urandom), 8'h3B, 16'h0000, 16'h0000);
    add_op(cfa_pkg::ACT_ADD16, 8'($urandom), 8'hC4, 16'h8000, 16'h8000);
    add_op(ACT_FIRST_UNUSED, 8'hA5, 8'h5A, 16'($urandom), 16'($urandom));
    add_op(ACT_LAST_CODE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    for (i = 0; i < RANDOM_OPS; i++) begin
      add_op(random_action(), random_byte(), random_byte(), random_word(), random_word());
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (pending_ops.size() != 0 || start);
    drain = 0;
    while (predicted_flag_results.size() != 0 && drain < 50) begin
      @(negedge clk);
      drain++;
    end
    repeat (6) @(negedge clk);
    if (predicted_flag_results.size() != 0) begin
      report_mismatch("missing result_value", 16'h0000, predicted_flag_results[0].value);
    end
    if (mismatch_count == 0) begin
      $display("cpu_flag_alu_core: match");
    end else begin
      $display("cpu_flag_alu_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("cpu_flag_alu_core: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/cfa_pkg.sv
rtl/cfa_exec.sv
rtl/cpu_flag_alu_core.sv
rtl/cfa_checker.sv
tb/cpu_flag_alu_core_tb.sv
